FILE: hw/rtl/rc4_pkg.sv
// Shared types, micro-op codes and constants for the RC4 stream cipher core.
package rc4_pkg;

  // Key length in bytes, clamped into 1..16 at elaboration.
  localparam int KEY_BYTES = 16;
  localparam int KEY_LEN   = (KEY_BYTES < 1) ? 1 : ((KEY_BYTES > 16) ? 16 : KEY_BYTES);
  localparam int KEY_W     = 128;
  localparam int KIDX_W    = 4;

  localparam logic [7:0] IDX_LAST = 8'hff;

  // Item kind carried on tuser
  localparam logic FUNC_SCHED = 1'b0;
  localparam logic FUNC_CRYPT = 1'b1;

  // Configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  typedef logic [3:0] step_t;

  // Memory read address select
  localparam logic [2:0] RD_NONE  = 3'd0;
  localparam logic [2:0] RD_N     = 3'd1;
  localparam logic [2:0] RD_JNEW  = 3'd2;
  localparam logic [2:0] RD_INEXT = 3'd3;
  localparam logic [2:0] RD_TSUM  = 3'd4;

  // Memory write select
  localparam logic [2:0] WR_NONE  = 3'd0;
  localparam logic [2:0] WR_INIT  = 3'd1;  // box[n] = n
  localparam logic [2:0] WR_N_RD  = 3'd2;  // box[n] = read data
  localparam logic [2:0] WR_I_RD  = 3'd3;  // box[i] = read data
  localparam logic [2:0] WR_J_TI  = 3'd4;  // box[j] = ti

  // j update
  localparam logic [1:0] J_HOLD  = 2'd0;
  localparam logic [1:0] J_CLEAR = 2'd1;
  localparam logic [1:0] J_KSA   = 2'd2;   // j + box[n] + key byte
  localparam logic [1:0] J_PRGA  = 2'd3;   // j + box[i]

  // i update
  localparam logic [1:0] I_HOLD  = 2'd0;
  localparam logic [1:0] I_CLEAR = 2'd1;
  localparam logic [1:0] I_INC   = 2'd2;

  // n and key index update
  localparam logic [1:0] N_HOLD  = 2'd0;
  localparam logic [1:0] N_CLEAR = 2'd1;
  localparam logic [1:0] N_INC   = 2'd2;

  // Branch kinds
  localparam logic [2:0] BR_NEXT     = 3'd0;
  localparam logic [2:0] BR_GOTO     = 3'd1;
  localparam logic [2:0] BR_DISPATCH = 3'd2;  // wait for item, crypt -> target
  localparam logic [2:0] BR_NLAST    = 3'd3;  // n != 255 -> target
  localparam logic [2:0] BR_WAIT_OUT = 3'd4;  // hold while output busy, then target

  // Microprogram step addresses
  localparam step_t ST_FETCH = 4'd0;
  localparam step_t ST_SCLR  = 4'd1;
  localparam step_t ST_INIT  = 4'd2;
  localparam step_t ST_KCLR  = 4'd3;
  localparam step_t ST_K1    = 4'd4;
  localparam step_t ST_K2    = 4'd5;
  localparam step_t ST_K3    = 4'd6;
  localparam step_t ST_K4    = 4'd7;
  localparam step_t ST_KEND  = 4'd8;
  localparam step_t ST_C1    = 4'd9;
  localparam step_t ST_C2    = 4'd10;
  localparam step_t ST_C3    = 4'd11;
  localparam step_t ST_C4    = 4'd12;
  localparam step_t ST_C5    = 4'd13;
  localparam step_t ST_C6    = 4'd14;

  typedef struct packed {
    logic [2:0] br;
    step_t      target;
    logic       accept;
    logic       emit;
    logic [2:0] rd;
    logic [2:0] wr;
    logic [1:0] j_op;
    logic [1:0] i_op;
    logic [1:0] n_op;
    logic       ld_ti;
    logic       ld_tj;
  } ctrl_t;

  typedef struct packed {
    logic n_last;
    logic out_busy;
  } stat_t;

endpackage

FILE: hw/rtl/rc4_seq.sv
// Microprogram ROM and step counter for the RC4 core.
module rc4_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           func,
  input  rc4_pkg::stat_t stat,
  output rc4_pkg::ctrl_t ctrl,
  output rc4_pkg::step_t step
);
  import rc4_pkg::*;

  step_t step_next;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '0;
    c.br = BR_NEXT;
    case (s)
      ST_FETCH: begin
        c.accept = 1'b1;
        c.br     = BR_DISPATCH;
        c.target = ST_C1;
      end
      ST_SCLR: begin
        c.n_op = N_CLEAR;
        c.j_op = J_CLEAR;
        c.i_op = I_CLEAR;
      end
      ST_INIT: begin
        c.wr     = WR_INIT;
        c.n_op   = N_INC;
        c.br     = BR_NLAST;
        c.target = ST_INIT;
      end
      ST_KCLR: c.n_op = N_CLEAR;
      ST_K1:   c.rd = RD_N;
      ST_K2: begin
        c.ld_ti = 1'b1;
        c.j_op  = J_KSA;
        c.rd    = RD_JNEW;
      end
      ST_K3:   c.wr = WR_N_RD;
      ST_K4: begin
        c.wr     = WR_J_TI;
        c.n_op   = N_INC;
        c.br     = BR_NLAST;
        c.target = ST_K1;
      end
      ST_KEND: begin
        c.i_op   = I_CLEAR;
        c.j_op   = J_CLEAR;
        c.br     = BR_GOTO;
        c.target = ST_FETCH;
      end
      ST_C1: begin
        c.i_op = I_INC;
        c.rd   = RD_INEXT;
      end
      ST_C2: begin
        c.ld_ti = 1'b1;
        c.j_op  = J_PRGA;
        c.rd    = RD_JNEW;
      end
      ST_C3: begin
        c.ld_tj = 1'b1;
        c.wr    = WR_I_RD;
      end
      ST_C4:   c.wr = WR_J_TI;
      ST_C5:   c.rd = RD_TSUM;
      ST_C6: begin
        c.emit   = 1'b1;
        c.br     = BR_WAIT_OUT;
        c.target = ST_FETCH;
      end
      default: begin
        c.br     = BR_GOTO;
        c.target = ST_FETCH;
      end
    endcase
    return c;
  endfunction

  assign ctrl = ucode(step);

  always_comb begin
    step_next = step + 4'd1;
    case (ctrl.br)
      BR_GOTO: step_next = ctrl.target;
      BR_DISPATCH: begin
        if (!in_valid) begin
          step_next = step;
        end else if (func == FUNC_CRYPT) begin
          step_next = ctrl.target;
        end
      end
      BR_NLAST: begin
        if (!stat.n_last) begin
          step_next = ctrl.target;
        end
      end
      BR_WAIT_OUT: begin
        step_next = stat.out_busy ? step : ctrl.target;
      end
      default: step_next = step + 4'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: hw/rtl/rc4_dp.sv
// Datapath of the RC4 core: key registers, indices, permutation box, output stage.
module rc4_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  rc4_pkg::ctrl_t            ctrl,
  output rc4_pkg::stat_t            stat,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [63:0]               cfg_data,
  input  logic                      in_valid,
  input  logic [7:0]                data_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                data_out
);
  import rc4_pkg::*;

  logic [KEY_W-1:0]  key;
  logic [7:0]        box [256];
  logic [7:0]        rdata;
  logic [7:0]        idx_i, idx_j, n;
  logic [KIDX_W-1:0] kidx;
  logic [7:0]        ti, tj, din;

  logic [7:0] key_byte, j_sum, rd_addr, wr_addr, wr_data;
  logic       rd_en, wr_en, load_out;

  assign key_byte = key[{kidx, 3'b000} +: 8];
  assign j_sum    = idx_j + rdata + ((ctrl.j_op == J_KSA) ? key_byte : 8'h00);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = n;
    case (ctrl.rd)
      RD_N:     rd_addr = n;
      RD_JNEW:  rd_addr = j_sum;
      RD_INEXT: rd_addr = idx_i + 8'd1;
      RD_TSUM:  rd_addr = ti + tj;
      default:  rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = n;
    wr_data = rdata;
    case (ctrl.wr)
      WR_INIT: wr_data = n;
      WR_N_RD: wr_addr = n;
      WR_I_RD: wr_addr = idx_i;
      WR_J_TI: begin
        wr_addr = idx_j;
        wr_data = ti;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Box: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      box[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= box[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_KEY_HIGH) begin
        key[127:64] <= cfg_data;
      end else begin
        key[63:0] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i <= '0;
      idx_j <= '0;
      n     <= '0;
      kidx  <= '0;
    end else begin
      case (ctrl.i_op)
        I_CLEAR: idx_i <= '0;
        I_INC:   idx_i <= idx_i + 8'd1;
        default: idx_i <= idx_i;
      endcase
      case (ctrl.j_op)
        J_CLEAR:       idx_j <= '0;
        J_KSA, J_PRGA: idx_j <= j_sum;
        default:       idx_j <= idx_j;
      endcase
      case (ctrl.n_op)
        N_CLEAR: begin
          n    <= '0;
          kidx <= '0;
        end
        N_INC: begin
          n    <= n + 8'd1;
          kidx <= (kidx == KIDX_W'(KEY_LEN - 1)) ? '0 : kidx + 1'b1;
        end
        default: begin
          n    <= n;
          kidx <= kidx;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_ti) begin
      ti <= rdata;
    end
    if (ctrl.ld_tj) begin
      tj <= rdata;
    end
    if (ctrl.accept && in_valid) begin
      din <= data_in;
    end
  end

  // Output register
  assign load_out = ctrl.emit && !(out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      data_out <= din ^ rdata;
    end
  end

  assign stat.n_last   = (n == IDX_LAST);
  assign stat.out_busy = out_valid && !out_ready;

endmodule

FILE: hw/rtl/rc4_stream_cipher_core.sv
// RC4 stream cipher core: top level joining the microcode sequencer and the datapath.
//
// Takes items of two kinds on the slave stream, chosen by s_tuser. A schedule
// item (tuser 0) loads the 256-byte permutation box with the identity, mixes in
// the key from the two key registers and clears i and j; it yields no output.
// The box memory has one write and one registered read per cycle, and each mixing
// step needs a read of box[n], a read of box[j] and two writes. A crypt item
// (tuser 1) steps i and j, swaps box[i] and box[j] and returns s_tdata XOR the
// keystream byte on the master stream, in steps that follow the chain of dependent
// box reads and writes through the single memory port pair. Encryption and
// decryption are the same. One item is in work at a time; a finished byte waits
// in the output register while the next item is fetched, and the core stalls
// only if a second result would overwrite it. Key bytes are taken low byte
// first: key byte 0 is cfg_data[7:0] written at index 0, key byte 8 is
// cfg_data[7:0] written at index 1. Write the key only while idle; it takes
// effect at the next schedule item. A crypt item before any schedule reads an
// unwritten box and its output is meaningless.
module rc4_stream_cipher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_in
  input  logic        s_tuser,   // [0] func: 0 key schedule, 1 crypt
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [7:0] data_out
);
  import rc4_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  step_t step;

  // Sequencer: steps through the control store, branches on item kind,
  // loop end and output backpressure
  rc4_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .func     (s_tuser),
    .stat     (stat),
    .ctrl     (ctrl),
    .step     (step)
  );

  // Datapath: box memory, indices, key and output register
  rc4_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .data_in   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .data_out  (m_tdata)
  );

  // Ready only in the fetch step
  assign s_tready = ctrl.accept;

  // An accepted item always leaves the fetch step
  a_leave_fetch: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sequencer stayed in fetch after accepting an item");

  // A result appears only from the final crypt step
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(step == ST_C6))
    else $error("output became valid outside the emit step");

  // Ready is tied to the fetch step
  a_ready_fetch: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> step == ST_FETCH)
    else $error("ready raised outside the fetch step");

endmodule

FILE: test/tb_top.sv
// Self-checking stream testbench for the RC4 stream cipher core.
module tb_top;
  import rc4_pkg::*;

  // A key schedule runs with nothing moving on either stream, so the settle
  // time and the watchdog both sit well above it.
  localparam int SETTLE_CYCLES    = 1400;
  localparam int QUIET_LIMIT      = 20000;
  localparam int RANDOM_PER_PHASE = 320;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic       func;
    logic [7:0] din;
  } stim_t;

  // Directed items. No keystream byte can be read off by eye, so every crypt
  // row is checked against the predictor below. Starts with a schedule, as a
  // crypt on an unscheduled box is out of contract.
  localparam int N_DIRECTED = 18;
  localparam stim_t DIRECTED_STIM [N_DIRECTED] = '{
    '{FUNC_SCHED, 8'h00},
    '{FUNC_CRYPT, 8'h00},   // bare keystream byte
    '{FUNC_CRYPT, 8'hff},
    '{FUNC_CRYPT, 8'h01},
    '{FUNC_CRYPT, 8'h80},
    '{FUNC_CRYPT, 8'h55},
    '{FUNC_CRYPT, 8'haa},
    '{FUNC_CRYPT, 8'h00},
    '{FUNC_SCHED, 8'hff},   // data byte must be ignored
    '{FUNC_CRYPT, 8'hff},
    '{FUNC_CRYPT, 8'hff},
    '{FUNC_SCHED, 8'h5a},   // two schedules back to back
    '{FUNC_SCHED, 8'h00},
    '{FUNC_CRYPT, 8'h00},
    '{FUNC_CRYPT, 8'h7f},
    '{FUNC_CRYPT, 8'hfe},
    '{FUNC_CRYPT, 8'h01},
    '{FUNC_CRYPT, 8'h80}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_KEY_LOW;
  logic [63:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [7:0] data_in
  logic        s_tuser = FUNC_SCHED;  // [0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // [7:0] data_out

  // Predictor state: our own copy of the box, indices and key registers
  logic [7:0]  perm [256];
  logic [7:0]  pos_i, pos_j;
  logic [63:0] key_lo, key_hi;

  logic [7:0]  cipher_bytes [$];   // expected output bytes, oldest first
  logic [7:0]  want_byte;
  int          fault_count = 0;
  int          quiet_cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  rc4_stream_cipher_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Standard RC4 key schedule over the first KEY_LEN key bytes, cycled
  function automatic void schedule_box();
    logic [7:0]   j;
    logic [7:0]   t;
    logic [127:0] key;
    key = {key_hi, key_lo};
    for (int n = 0; n < 256; n++) perm[n] = n[7:0];
    j = 8'd0;
    for (int n = 0; n < 256; n++) begin
      j = j + perm[n] + key[8 * (n % KEY_LEN) +: 8];
      t = perm[n];
      perm[n] = perm[j];
      perm[j] = t;
    end
    pos_i = 8'd0;
    pos_j = 8'd0;
  endfunction

  // One PRGA step: advance i and j, swap, XOR the keystream byte in
  function automatic logic [7:0] crypt_byte(input logic [7:0] din);
    logic [7:0] t;
    pos_i = pos_i + 8'd1;
    pos_j = pos_j + perm[pos_i];
    t = perm[pos_i];
    perm[pos_i] = perm[pos_j];
    perm[pos_j] = t;
    t = perm[pos_i] + perm[pos_j];   // 8-bit wrap is the mod 256
    return din ^ perm[t];
  endfunction

  function automatic void flag_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // Offer one item, with random idle cycles ahead of it; predict on acceptance
  task automatic send_item(input logic func, input logic [7:0] din);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= din;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (func == FUNC_SCHED) schedule_box();
    else cipher_bytes.push_back(crypt_byte(din));
  endtask

  // Key writes go in on consecutive edges; only called with the core idle
  task automatic write_key(input logic [63:0] lo, input logic [63:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    key_lo     = lo;
    cfg_index <= CFG_KEY_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    key_hi  = hi;
    cfg_we <= 1'b0;
  endtask

  // Wait for every expected byte, then let a schedule in flight run out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (cipher_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One phase: new key, optional directed items, then random sessions.
  // A session is a schedule followed by a run of crypt items; about one run
  // in four is long enough to wrap i, and runs are cut to fit the phase.
  // With keep_box the first session skips its schedule, so the new key must
  // not disturb the running box.
  task automatic run_phase(input int idle, input int stall,
                           input logic [63:0] lo, input logic [63:0] hi,
                           input logic directed, input logic keep_box);
    int   sent;
    int   run_len;
    logic first;
    idle_pct  = idle;
    stall_pct = stall;
    write_key(lo, hi);
    if (directed) begin
      for (int r = 0; r < N_DIRECTED; r++)
        send_item(DIRECTED_STIM[r].func, DIRECTED_STIM[r].din);
    end
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_PER_PHASE) begin
      if (!(first && keep_box)) send_item(FUNC_SCHED, 8'($urandom_range(255)));
      first = 1'b0;
      run_len = ($urandom_range(3) == 0) ? $urandom_range(260, 400)
                                         : $urandom_range(1, 40);
      if (run_len > RANDOM_PER_PHASE - sent) run_len = RANDOM_PER_PHASE - sent;
      repeat (run_len) begin
        send_item(FUNC_CRYPT, 8'($urandom_range(255)));
        sent++;
      end
    end
    drain();
  endtask

  // Output side: check each accepted byte, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (cipher_bytes.size() == 0) begin
        flag_fault($sformatf("unexpected output byte %02h", m_tdata));
      end else begin
        want_byte = cipher_bytes.pop_front();
        if (m_tdata !== want_byte)
          flag_fault($sformatf("data_out expected %02h got %02h", want_byte, m_tdata));
      end
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: too long with no item moving and no key write means a hang
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    key_lo = '0;
    key_hi = '0;
    pos_i  = 8'd0;
    pos_j  = 8'd0;
    for (int n = 0; n < 256; n++) perm[n] = 8'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero key, no back-pressure either side, directed items first
    run_phase(0, 0, 64'h0, 64'h0, 1'b1, 1'b0);
    // all-ones key, sender gaps
    run_phase(48, 0, '1, '1, 1'b0, 1'b1);
    // random key, receiver stalls
    run_phase(0, 48, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b1);
    // mixed key with single-bit extremes in the high word, both sides idling
    run_phase(24, 24, {$urandom, $urandom}, 64'h8000_0000_0000_0001, 1'b0, 1'b1);

    if (cipher_bytes.size() != 0)
      flag_fault($sformatf("%0d expected bytes never arrived", cipher_bytes.size()));
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_seq.sv
hw/rtl/rc4_dp.sv
hw/rtl/rc4_stream_cipher_core.sv
test/tb_top.sv
